// ===== rtl/apid_pkg.sv =====
// ----------------------------------------------------------------------------
// apid_pkg
// Shared types, constants and fixed-point helpers of the PID controller.
// ----------------------------------------------------------------------------
package apid_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int TIME_W    = 24;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  localparam int US_PER_S  = 1000000;
  localparam int HALF_US   = US_PER_S / 2;
  localparam int US_W      = 20;

  // iterative divider: quotient bits per round and dividend width
  localparam int DIV_RADIX = 4;
  localparam int DIV_W     = 84;
  localparam int RND_W     = 5;
  localparam int INT_DIV_W = DATA_W + TIME_W;
  localparam int DIV_ROUNDS_I = INT_DIV_W / DIV_RADIX;
  localparam int DIV_ROUNDS_D = DIV_W / DIV_RADIX;

  localparam logic [OP_W-1:0] OP_TARGET = 2'd0;
  localparam logic [OP_W-1:0] OP_MEAS   = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 3'd5;

  // datapath step codes
  localparam logic [3:0] DP_NONE  = 4'd0;
  localparam logic [3:0] DP_LOAD  = 4'd1;
  localparam logic [3:0] DP_EXEC  = 4'd2;
  localparam logic [3:0] DP_MUL   = 4'd3;
  localparam logic [3:0] DP_PREP  = 4'd4;
  localparam logic [3:0] DP_SCALE = 4'd5;
  localparam logic [3:0] DP_DSUM  = 4'd6;
  localparam logic [3:0] DP_INTEG = 4'd7;
  localparam logic [3:0] DP_IMUL  = 4'd8;
  localparam logic [3:0] DP_IRND  = 4'd9;
  localparam logic [3:0] DP_DRND  = 4'd10;
  localparam logic [3:0] DP_SUM   = 4'd11;
  localparam logic [3:0] DP_CTRL  = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] reset_control;
    logic [TIME_W-1:0]        elapsed_us;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] control_value;
    logic signed [DATA_W-1:0] control_change;
    logic                     skipped;
  } out_t;

  typedef struct packed {
    logic [3:0] step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            dt_zero;
    logic            div_busy;
  } sts_t;

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
    mag32 = x[DATA_W-1] ? (DATA_W'(0) - unsigned'(x)) : unsigned'(x);
  endfunction

  // signed result from sign and magnitude, saturated
  function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                       input logic [71:0] m);
    logic [DATA_W-1:0] lo;
    lo = m[DATA_W-1:0];
    if (neg) begin
      if (m > 72'h0_8000_0000) sat_mag = 32'sh8000_0000;
      else sat_mag = signed'(DATA_W'(0) - lo);
    end else begin
      if (m > 72'h0_7FFF_FFFF) sat_mag = 32'sh7FFF_FFFF;
      else sat_mag = signed'(lo);
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] sat36(input logic signed [35:0] x);
    if (x > 36'sh0_7FFF_FFFF) sat36 = 32'sh7FFF_FFFF;
    else if (x < 36'shF_8000_0000) sat36 = 32'sh8000_0000;
    else sat36 = x[DATA_W-1:0];
  endfunction

  function automatic logic signed [35:0] sx36(input logic signed [DATA_W-1:0] x);
    sx36 = {{(36-DATA_W){x[DATA_W-1]}}, x};
  endfunction

endpackage

// ===== rtl/apid_div.sv =====
// ----------------------------------------------------------------------------
// apid_div
// Restoring unsigned divider, DIV_RADIX quotient bits per clock.
// ----------------------------------------------------------------------------
module apid_div import apid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [TIME_W-1:0] divisor,
  input  logic [RND_W-1:0]  rounds,
  output logic [DIV_W-1:0]  quotient,
  output logic [TIME_W-1:0] remainder,
  output logic              busy
);

  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [RND_W-1:0]  cnt_r;
  logic              busy_r;
  logic [TIME_W:0]   rt;

  always_comb begin
    q_nxt = q_r;
    rt    = {1'b0, rem_r};
    for (int k = 0; k < DIV_RADIX; k++) begin
      rt    = {rt[TIME_W-1:0], q_nxt[DIV_W-1]};
      q_nxt = {q_nxt[DIV_W-2:0], 1'b0};
      if (rt >= {1'b0, dvs_r}) begin
        rt       = rt - {1'b0, dvs_r};
        q_nxt[0] = 1'b1;
      end
    end
    rem_nxt = rt[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= rounds;
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == RND_W'(1)) busy_r <= 1'b0;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign busy      = busy_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("divider busy with no rounds left");

endmodule

// ===== rtl/apid_datapath.sv =====
// ----------------------------------------------------------------------------
// apid_datapath
// Configuration, controller state and arithmetic steps of the PID update.
// ----------------------------------------------------------------------------
module apid_datapath import apid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output out_t                 out_data
);

  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, floor_r, ceil_r;
  logic [DATA_W-2:0]        lim_r;
  logic signed [DATA_W-1:0] target_r, meas_r, err_r, errp_r, acc_r, ctrl_r, chg_r;
  in_t                      in_r;
  logic                     skip_r;
  out_t                     out_r;

  logic [2*DATA_W-1:0]      pp_r, pi_r;
  logic [INT_DIV_W-1:0]     pt_r;
  logic signed [DATA_W:0]   de_r;
  logic [2*DATA_W:0]        pd_r;
  logic [DATA_W+US_W:0]     dlo_r;
  logic [DATA_W+US_W-1:0]   dhi_r;
  logic [DIV_W-1:0]         ddiv_r;
  logic signed [DATA_W-1:0] p_r, i_r, d_r;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dvd, div_q;
  logic [TIME_W-1:0]        div_dvs, div_rem;
  logic [RND_W-1:0]         div_rounds;
  logic                     div_busy;

  logic [DATA_W:0]          de_mag;
  logic [INT_DIV_W:0]       istep_mag;
  logic signed [DATA_W-1:0] istep;
  logic signed [35:0]       acc_sum, lim_p, lim_n, ctl_sum;
  logic signed [DATA_W-1:0] ctl_sat;
  logic [2*DATA_W:0]        pp_rnd, pi_rnd;
  logic [DIV_W:0]           d_rnd;

  assign div_start  = (cmd.step == DP_PREP) || (cmd.step == DP_IRND);
  assign div_dvd    = (cmd.step == DP_PREP) ? {pt_r, (DIV_W-INT_DIV_W)'(0)} : ddiv_r;
  assign div_dvs    = (cmd.step == DP_PREP) ? TIME_W'(US_PER_S) : in_r.elapsed_us;
  assign div_rounds = (cmd.step == DP_PREP) ? RND_W'(DIV_ROUNDS_I) : RND_W'(DIV_ROUNDS_D);

  apid_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .rounds    (div_rounds),
    .quotient  (div_q),
    .remainder (div_rem),
    .busy      (div_busy)
  );

  always_comb begin
    de_mag    = de_r[DATA_W] ? ((DATA_W+1)'(0) - unsigned'(de_r)) : unsigned'(de_r);
    istep_mag = (INT_DIV_W+1)'(div_q[INT_DIV_W-1:0])
              + (INT_DIV_W+1)'(div_rem >= TIME_W'(HALF_US));
    istep     = sat_mag(err_r[DATA_W-1], 72'(istep_mag));
    acc_sum   = sx36(acc_r) + sx36(istep);
    lim_p     = 36'(lim_r);
    lim_n     = 36'sd0 - lim_p;
    ctl_sum   = sx36(ctrl_r) + sx36(chg_r);
    ctl_sat   = sat36(ctl_sum);
    pp_rnd    = ({1'b0, pp_r} + (2*DATA_W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
    pi_rnd    = ({1'b0, pi_r} + (2*DATA_W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
    d_rnd     = ({1'b0, div_q} + (DIV_W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      lim_r   <= '0;
      floor_r <= '0;
      ceil_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:    kp_r    <= signed'(cfg_data);
        CFG_KI:    ki_r    <= signed'(cfg_data);
        CFG_KD:    kd_r    <= signed'(cfg_data);
        CFG_LIM:   lim_r   <= cfg_data[DATA_W-2:0];
        CFG_FLOOR: floor_r <= signed'(cfg_data);
        CFG_CEIL:  ceil_r  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      meas_r   <= '0;
      err_r    <= '0;
      errp_r   <= '0;
      acc_r    <= '0;
      ctrl_r   <= '0;
      chg_r    <= '0;
      skip_r   <= 1'b0;
    end else begin
      case (cmd.step)
        DP_LOAD: in_r <= in_data;
        DP_EXEC: begin
          skip_r <= (in_r.operation == OP_UPDATE) && (in_r.elapsed_us == '0);
          case (in_r.operation)
            OP_TARGET: begin
              target_r <= in_r.value;
              err_r    <= sat36(sx36(in_r.value) - sx36(meas_r));
              errp_r   <= sat36(sx36(in_r.value) - sx36(meas_r));
            end
            OP_MEAS: begin
              meas_r <= in_r.value;
              err_r  <= sat36(sx36(target_r) - sx36(in_r.value));
            end
            OP_RESET: begin
              target_r <= in_r.value;
              meas_r   <= in_r.value;
              ctrl_r   <= in_r.reset_control;
              err_r    <= '0;
              errp_r   <= '0;
              acc_r    <= '0;
              chg_r    <= '0;
            end
            default: ;
          endcase
        end
        DP_MUL: begin
          pp_r <= mag32(err_r) * mag32(kp_r);
          pt_r <= mag32(err_r) * in_r.elapsed_us;
          de_r <= {err_r[DATA_W-1], err_r} - {errp_r[DATA_W-1], errp_r};
        end
        DP_PREP: begin
          p_r  <= sat_mag(err_r[DATA_W-1] ^ kp_r[DATA_W-1], 72'(pp_rnd));
          pd_r <= de_mag * mag32(kd_r);
        end
        DP_SCALE: begin
          dlo_r <= pd_r[DATA_W:0] * US_W'(US_PER_S);
          dhi_r <= pd_r[2*DATA_W:DATA_W+1] * US_W'(US_PER_S);
        end
        DP_DSUM: ddiv_r <= DIV_W'({dhi_r, (DATA_W+1)'(0)}) + DIV_W'(dlo_r);
        DP_INTEG: begin
          if (acc_sum > lim_p) acc_r <= lim_p[DATA_W-1:0];
          else if (acc_sum < lim_n) acc_r <= lim_n[DATA_W-1:0];
          else acc_r <= acc_sum[DATA_W-1:0];
        end
        DP_IMUL: pi_r <= mag32(acc_r) * mag32(ki_r);
        DP_IRND: i_r <= sat_mag(acc_r[DATA_W-1] ^ ki_r[DATA_W-1], 72'(pi_rnd));
        DP_DRND: d_r <= sat_mag(de_r[DATA_W] ^ kd_r[DATA_W-1], 72'(d_rnd));
        DP_SUM: chg_r <= sat36(sx36(p_r) + sx36(i_r) + sx36(d_r));
        DP_CTRL: begin
          if (ctl_sat > ceil_r) ctrl_r <= ceil_r;
          else if (ctl_sat < floor_r) ctrl_r <= floor_r;
          else ctrl_r <= ctl_sat;
          errp_r <= err_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.control_value  <= skip_r ? '0 : ctrl_r;
      out_r.control_change <= chg_r;
      out_r.skipped        <= skip_r;
    end
  end

  assign out_data     = out_r;
  assign sts.op       = in_r.operation;
  assign sts.dt_zero  = (in_r.elapsed_us == '0);
  assign sts.div_busy = div_busy;

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step == DP_INTEG |=> (sx36(acc_r) <= lim_p) && (sx36(acc_r) >= lim_n))
    else $error("integral outside limit");
  a_ctrl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == DP_CTRL) && (floor_r <= ceil_r) |=>
      (ctrl_r >= floor_r) && (ctrl_r <= ceil_r))
    else $error("control value outside floor and ceiling");
  a_div_idle_use: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == DP_INTEG) || (cmd.step == DP_DRND) |-> !div_busy)
    else $error("divider result used while busy");

endmodule

// ===== rtl/apid_ctrl.sv =====
// ----------------------------------------------------------------------------
// apid_ctrl
// Sequencer: steps the datapath through one request and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module apid_ctrl import apid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXEC  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_PREP  = 4'd3;
  localparam logic [3:0] ST_SCALE = 4'd4;
  localparam logic [3:0] ST_DSUM  = 4'd5;
  localparam logic [3:0] ST_WAITI = 4'd6;
  localparam logic [3:0] ST_INTEG = 4'd7;
  localparam logic [3:0] ST_IMUL  = 4'd8;
  localparam logic [3:0] ST_IRND  = 4'd9;
  localparam logic [3:0] ST_WAITD = 4'd10;
  localparam logic [3:0] ST_DRND  = 4'd11;
  localparam logic [3:0] ST_SUM   = 4'd12;
  localparam logic [3:0] ST_CTRL  = 4'd13;
  localparam logic [3:0] ST_FIN   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.step     = DP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = DP_LOAD;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.step  = DP_EXEC;
        state_nxt = ((sts.op == OP_UPDATE) && !sts.dt_zero) ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.step  = DP_MUL;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.step  = DP_PREP;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.step  = DP_SCALE;
        state_nxt = ST_DSUM;
      end
      ST_DSUM: begin
        cmd.step  = DP_DSUM;
        state_nxt = ST_WAITI;
      end
      ST_WAITI: if (!sts.div_busy) state_nxt = ST_INTEG;
      ST_INTEG: begin
        cmd.step  = DP_INTEG;
        state_nxt = ST_IMUL;
      end
      ST_IMUL: begin
        cmd.step  = DP_IMUL;
        state_nxt = ST_IRND;
      end
      ST_IRND: begin
        cmd.step  = DP_IRND;
        state_nxt = ST_WAITD;
      end
      ST_WAITD: if (!sts.div_busy) state_nxt = ST_DRND;
      ST_DRND: begin
        cmd.step  = DP_DRND;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.step  = DP_SUM;
        state_nxt = ST_CTRL;
      end
      ST_CTRL: begin
        cmd.step  = DP_CTRL;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish");

endmodule

// ===== rtl/accumulating_pid_controller.sv =====
// ----------------------------------------------------------------------------
// accumulating_pid_controller
// PID regulator in signed Q16.16 with integral clamp and output limits.
// ----------------------------------------------------------------------------
// One request at a time. Set target, set measurement, reset and an update
// with zero elapsed time go from the execute step straight to finish.
// A full update runs the shared divider twice, and the divider
// retires 4 quotient bits per clock: 14 rounds for the integral step (error
// times dt over one million) and 21 rounds for the derivative (error change
// times gain times one million over dt). A new request is taken once the
// previous one has reached the output register. Configuration writes are
// always ready and must be issued only while the block is idle.
module accumulating_pid_controller import apid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  apid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  apid_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accumulating PID controller: drives requests
// and register writes over valid/ready channels, predicts every result with
// a bit-exact Q16.16 model of its own and compares the results field by field.
// ----------------------------------------------------------------------------
module tb;
  import apid_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int     QUIET_LIMIT = 5000;
  localparam int     LONG_HOLD = 300;

  class pid_scoreboard;
    longint kp, ki, kd, lim, floor_q, ceil_q;
    longint target, meas, err_now, err_prev, accum, ctrl, change;
    out_t   pending_q[$];
    int     errors, n_req, n_res, n_cfg;

    function new();
      kp = 0; ki = 0; kd = 0; lim = 0; floor_q = 0; ceil_q = 0;
      target = 0; meas = 0; err_now = 0; err_prev = 0;
      accum = 0; ctrl = 0; change = 0;
      errors = 0; n_req = 0; n_res = 0; n_cfg = 0;
    endfunction

    function longint sat_q(longint x);
      return x > Q_MAX ? Q_MAX : (x < Q_MIN ? Q_MIN : x);
    endfunction

    function logic [63:0] abs_q(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function longint from_mag(bit neg, logic [127:0] m);
      if (neg) return m > 128'h8000_0000 ? Q_MIN : -longint'(m[63:0]);
      return m > 128'h7FFF_FFFF ? Q_MAX : longint'(m[63:0]);
    endfunction

    function longint mul_q(longint a, longint b);
      logic [127:0] p;
      p = 128'(abs_q(a)) * 128'(abs_q(b));
      p = (p + 128'd32768) >> FRAC_BITS;
      return from_mag((a < 0) != (b < 0), p);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      n_cfg++;
      case (idx)
        CFG_KP:    kp = longint'($signed(d));
        CFG_KI:    ki = longint'($signed(d));
        CFG_KD:    kd = longint'($signed(d));
        CFG_LIM:   lim = longint'({33'b0, d[30:0]});
        CFG_FLOOR: floor_q = longint'($signed(d));
        CFG_CEIL:  ceil_q = longint'($signed(d));
        default:   ;
      endcase
    endfunction

    function void note(in_t x);
      longint val, p, i, d, de;
      logic [127:0] w, r;
      logic [63:0] dt;
      bit skip;
      out_t e;
      val = longint'(x.value);
      dt = 64'(x.elapsed_us);
      skip = 0;
      n_req++;
      case (x.operation)
        OP_TARGET: begin
          target = val;
          err_now = sat_q(target - meas);
          err_prev = err_now;
        end
        OP_MEAS: begin
          meas = val;
          err_now = sat_q(target - meas);
        end
        OP_RESET: begin
          target = val; meas = val;
          ctrl = longint'(x.reset_control);
          err_now = 0; err_prev = 0; accum = 0; change = 0;
        end
        default: begin
          if (dt == 0) begin
            skip = 1;
          end else begin
            p = mul_q(err_now, kp);
            w = 128'(abs_q(err_now)) * 128'(dt);
            r = w % 128'd1000000;
            w = w / 128'd1000000;
            if (r * 2 >= 128'd1000000) w = w + 1;
            accum = accum + from_mag(err_now < 0, w);
            if (accum > lim) accum = lim;
            else if (accum < -lim) accum = -lim;
            i = mul_q(accum, ki);
            de = err_now - err_prev;
            w = 128'(abs_q(de)) * 128'(abs_q(kd)) * 128'd1000000;
            w = w / 128'(dt);
            w = (w + 128'd32768) >> FRAC_BITS;
            d = from_mag((de < 0) != (kd < 0), w);
            change = sat_q(p + i + d);
            ctrl = sat_q(ctrl + change);
            if (ctrl > ceil_q) ctrl = ceil_q;
            else if (ctrl < floor_q) ctrl = floor_q;
            err_prev = err_now;
          end
        end
      endcase
      e.control_value  = skip ? '0 : DATA_W'(ctrl);
      e.control_change = DATA_W'(change);
      e.skipped        = skip;
      pending_q.push_back(e);
    endfunction

    function void check(out_t got);
      out_t e;
      n_res++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: control_value %0d", got.control_value);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.control_value !== e.control_value) begin
        $error("control_value: expected %0d, actual %0d", e.control_value, got.control_value);
        errors++;
      end
      if (got.control_change !== e.control_change) begin
        $error("control_change: expected %0d, actual %0d", e.control_change,
               got.control_change);
        errors++;
      end
      if (got.skipped !== e.skipped) begin
        $error("skipped: expected %0d, actual %0d", e.skipped, got.skipped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  pid_scoreboard sb = new();
  bit idle_en = 1'b1;
  bit hold_out = 1'b0;
  int quiet_cycles = 0;
  int n_phase = 0;

  accumulating_pid_controller i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) sb.note(in_data);
    if (out_valid && out_ready) sb.check(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [DATA_W-1:0] rnd_q();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h4_0000))
                                           : -32'($urandom_range(0, 32'h4_0000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rnd_dt();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1, 50000));
    endcase
  endfunction

  function automatic in_t make_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] v,
                                   logic [DATA_W-1:0] rc, logic [TIME_W-1:0] dt);
    in_t x;
    x.operation = op; x.value = v; x.reset_control = rc; x.elapsed_us = dt;
    return x;
  endfunction

  task automatic send_req(in_t x);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  task automatic write_cfg(logic [DATA_W-1:0] r [6]);
    cfg_valid <= 1'b1;
    for (int k = 0; k < 7; k++) begin
      cfg_index <= k < 6 ? CFG_IDX_W'(k) : CFG_IDX_W'(7);
      cfg_data  <= k < 6 ? r[k] : $urandom;
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(cfg_index, cfg_data);
    end
    cfg_valid <= 1'b0;
    n_phase++;
  endtask

  task automatic pick_cfg(int mode);
    logic [DATA_W-1:0] r [6];
    case (mode)
      0: r = '{32'h0001_0000, 32'h0000_8000, 32'h0000_0290, 32'h0064_0000,
               32'hFC18_0000, 32'h03E8_0000};
      1: r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF};
      2: r = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
               32'h8000_0000, 32'h7FFF_FFFF};
      3: r = '{32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0100_0000,
               32'h0010_0000, 32'hFFF0_0000};
      default: for (int k = 0; k < 6; k++) r[k] = rnd_q();
    endcase
    write_cfg(r);
  endtask

  task automatic random_reqs(int n);
    in_t x;
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1:   x = make_req(OP_TARGET, rnd_q(), $urandom, $urandom);
        2:      x = make_req(OP_RESET, rnd_q(), rnd_q(), $urandom);
        3, 4, 5, 6, 7, 8, 9:
                x = make_req(OP_MEAS, rnd_q(), $urandom, $urandom);
        default: x = make_req(OP_UPDATE, $urandom, $urandom, rnd_dt());
      endcase
      send_req(x);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults first, then moderate gains
    send_req(make_req(OP_UPDATE, 0, 0, 24'd1000));
    drain();
    pick_cfg(0);
    send_req(make_req(OP_TARGET, 32'h0010_0000, 0, 0));
    send_req(make_req(OP_MEAS, 32'h0008_0000, 0, 0));
    send_req(make_req(OP_UPDATE, 0, 0, 24'd0));
    send_req(make_req(OP_UPDATE, 0, 0, 24'd1));
    send_req(make_req(OP_MEAS, 32'h000C_0000, 0, 0));
    send_req(make_req(OP_UPDATE, 0, 0, 24'hFF_FFFF));
    send_req(make_req(OP_TARGET, 32'h7FFF_FFFF, 0, 0));
    send_req(make_req(OP_MEAS, 32'h8000_0000, 0, 0));
    send_req(make_req(OP_UPDATE, 0, 0, 24'd1));
    send_req(make_req(OP_UPDATE, 0, 0, 24'hFF_FFFF));
    send_req(make_req(OP_TARGET, 32'h8000_0000, 0, 0));
    send_req(make_req(OP_MEAS, 32'h7FFF_FFFF, 0, 0));
    send_req(make_req(OP_UPDATE, 0, 0, 24'd500));
    send_req(make_req(OP_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_req(make_req(OP_UPDATE, 0, 0, 24'd10));
    send_req(make_req(OP_RESET, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_req(make_req(OP_MEAS, 32'h0000_0000, 0, 0));
    send_req(make_req(OP_UPDATE, 0, 0, 24'd20000));
    send_req(make_req(OP_UPDATE, 0, 0, 24'd0));
    drain();

    // extremes, floor above ceiling, long result stall
    pick_cfg(1);
    random_reqs(20);
    hold_out = 1'b1;
    random_reqs(60);
    drain();
    pick_cfg(3);
    random_reqs(80);
    drain();
    pick_cfg(2);
    random_reqs(80);
    drain();
    pick_cfg(4);
    random_reqs(80);
    drain();
    pick_cfg(4);
    random_reqs(80);
    drain();
    idle_en = 1'b0;
    pick_cfg(0);
    random_reqs(80);
    drain();
    repeat (60) @(posedge clk);

    $display("Ran %0d requests with %0d results checked across %0d register settings",
             sb.n_req, sb.n_res, n_phase);
    $display("Settings included saturated gains, a zero integral limit and floor above ceiling");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
